/* sv/hdlc_bit_deframer_macros.svh */
`ifndef HDLC_BIT_DEFRAMER_MACROS_SVH
`define HDLC_BIT_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define HDF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define HDF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hdlc_df_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hdlc_df_pkg;

   localparam int FRAME_BYTES_DEF = 512;

   localparam int INDEX_W = 9;
   localparam int EVENT_W = 2;
   localparam int LEN_W   = 10;
   localparam int BYTE_W  = 8;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
   localparam logic [EVENT_W-1:0] EV_GOOD = 2'd1;
   localparam logic [EVENT_W-1:0] EV_FAIL = 2'd2;
   localparam logic [EVENT_W-1:0] EV_READ = 2'd3;

   localparam logic [7:0] FLAG_PAT   = 8'h7E;
   localparam logic [7:0] ABORT_MASK = 8'h7F;
   localparam logic [7:0] STUFF_MASK = 8'h3F;
   localparam logic [7:0] STUFF_PAT  = 8'h3E;

   // Flag bits already stored when the flag is recognized
   localparam int FLAG_BITS       = 7;
   localparam int MIN_CLOSE_BYTES = 2;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [15:0] FCS_RESIDUE = 16'hF0B8;

   typedef struct packed {
      logic               opcode;
      logic               line_bit;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [LEN_W-1:0]   frame_length;
      logic [BYTE_W-1:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic       is_read;
      logic       store;
      logic       restart;
      logic       boundary;
      logic       bit_val;
      logic [2:0] bit_pos;
      logic       sel_prev;
      logic       closing;
   } ctl_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic din);
      logic fb;
      fb = crc[0] ^ din;
      return fb ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
   endfunction

endpackage

`default_nettype wire

/* sv/hdlc_df_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module hdlc_df_ctrl #(
   parameter int FRAME_BYTES = hdlc_df_pkg::FRAME_BYTES_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 go,
   input  wire hdlc_df_pkg::req_type           item,
   output hdlc_df_pkg::ctl_type                ctl,
   output logic [$clog2(FRAME_BYTES)-1:0]      wr_pos,
   output logic [hdlc_df_pkg::LEN_W-1:0]       frame_len
);

   `include "hdlc_bit_deframer_macros.svh"

   localparam int CW   = $clog2(FRAME_BYTES * 8 + 1);
   localparam int AW   = $clog2(FRAME_BYTES);
   localparam int NB_W = CW - 3;

   logic [7:0]    hist_ff, hist_in;
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] count_m7;
   logic [NB_W-1:0] nbytes;
   logic          push, is_flag, is_abort, is_stuff, is_full, ge7;
   logic          store, restart;

   assign push     = go && (item.opcode == hdlc_df_pkg::OP_PUSH);
   assign hist_in  = {hist_ff[6:0], item.line_bit};
   assign is_flag  = hist_in == hdlc_df_pkg::FLAG_PAT;
   assign is_abort = (hist_in & hdlc_df_pkg::ABORT_MASK) == hdlc_df_pkg::ABORT_MASK;
   assign is_stuff = (hist_in & hdlc_df_pkg::STUFF_MASK) == hdlc_df_pkg::STUFF_PAT;
   assign is_full  = count_ff >= CW'(FRAME_BYTES * 8);
   assign ge7      = count_ff >= CW'(hdlc_df_pkg::FLAG_BITS);
   assign count_m7 = count_ff - CW'(hdlc_df_pkg::FLAG_BITS);
   assign nbytes   = count_m7[CW-1:3];

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      store       = 1'b0;
      restart     = 1'b0;
      if (push) begin
         if (is_flag) begin
            in_frame_in = 1'b1;
            count_in    = '0;
            restart     = 1'b1;
         end else if (!in_frame_ff) begin
            // hunt for a flag
         end else if (is_abort || (!is_stuff && is_full)) begin
            in_frame_in = 1'b0;
            count_in    = '0;
            restart     = 1'b1;
         end else if (!is_stuff) begin
            store    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      ctl          = '0;
      ctl.go       = go;
      ctl.is_read  = go && (item.opcode == hdlc_df_pkg::OP_READ);
      ctl.store    = store;
      ctl.restart  = restart;
      ctl.boundary = store && (count_ff[2:0] == 3'd7);
      ctl.bit_val  = item.line_bit;
      ctl.bit_pos  = count_ff[2:0];
      // check bytes end at the last byte boundary only when the count sits at 7 mod 8
      ctl.sel_prev = count_ff[2:0] != 3'd7;
      ctl.closing  = push && is_flag && in_frame_ff && ge7 &&
                     (nbytes > NB_W'(hdlc_df_pkg::MIN_CLOSE_BYTES));
   end

   assign wr_pos    = count_ff[AW+2:3];
   assign frame_len = hdlc_df_pkg::LEN_W'(nbytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
      end else if (push) begin
         hist_ff     <= hist_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   `HDF_ASSERT_NOW(a_idle_count_zero, !in_frame_ff, count_ff == '0,
      "bit count not zero outside a frame")
   `HDF_ASSERT_NOW(a_store_in_range, store, in_frame_ff && (count_ff < CW'(FRAME_BYTES * 8)),
      "data bit stored outside a frame or past the store")

endmodule

`default_nettype wire

/* sv/hdlc_df_fcs.sv */
`timescale 1ns / 1ps
`default_nettype none

module hdlc_df_fcs (
   input  wire                   clock,
   input  wire                   reset,
   input  wire hdlc_df_pkg::ctl_type ctl,
   output logic                  fcs_ok
);

   `include "hdlc_bit_deframer_macros.svh"

   logic [15:0] crc_ff, crc_in;
   logic [15:0] last_ff, prev_ff;

   assign crc_in = hdlc_df_pkg::crc_step(crc_ff, ctl.bit_val);
   assign fcs_ok = (ctl.sel_prev ? prev_ff : last_ff) == hdlc_df_pkg::FCS_RESIDUE;

   // Keep the check value at the two most recent byte boundaries
   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         crc_ff  <= hdlc_df_pkg::CRC_INIT;
         last_ff <= hdlc_df_pkg::CRC_INIT;
         prev_ff <= hdlc_df_pkg::CRC_INIT;
      end else if (ctl.store) begin
         crc_ff <= crc_in;
         if (ctl.boundary) begin
            prev_ff <= last_ff;
            last_ff <= crc_in;
         end
      end
   end

   `HDF_ASSERT_NEXT(a_restart_init, ctl.restart,
      (crc_ff == hdlc_df_pkg::CRC_INIT) && (last_ff == hdlc_df_pkg::CRC_INIT),
      "check register not restarted")

endmodule

`default_nettype wire

/* sv/hdlc_df_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module hdlc_df_store #(
   parameter int FRAME_BYTES = hdlc_df_pkg::FRAME_BYTES_DEF
) (
   input  wire                                     clock,
   input  wire hdlc_df_pkg::ctl_type               ctl,
   input  wire [$clog2(FRAME_BYTES)-1:0]           wr_pos,
   input  wire [hdlc_df_pkg::INDEX_W-1:0]          read_index,
   output logic [hdlc_df_pkg::BYTE_W-1:0]          read_byte
);

   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] acc_ff, acc_in;
   logic [7:0] rd_ff;
   logic       in_range;

   // Start a fresh byte at bit 0, otherwise merge the new bit
   assign acc_in   = (ctl.bit_pos == 3'd0) ? {7'd0, ctl.bit_val}
                                           : (acc_ff | (8'(ctl.bit_val) << ctl.bit_pos));
   assign in_range = 32'(read_index) < FRAME_BYTES;

   always_ff @(posedge clock) begin
      if (ctl.store) begin
         mem[wr_pos] <= acc_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.is_read && in_range) begin
         rd_ff <= mem[AW'(read_index)];
      end else if (ctl.go) begin
         rd_ff <= '0;
      end
   end

   assign read_byte = rd_ff;

endmodule

`default_nettype wire

/* sv/hdlc_bit_deframer.sv */
// An accepted item passes the input register and then the result register on its way to rsp.
// Throughput: 1 item per cycle unless rsp_stall holds a full result register; one line bit or one
// byte read each cycle, set by the flag/stuffing logic and the running bit-serial check register.
// Reset: synchronous, active high; clears the bit history, frame state, bit count,
// check register and both valid registers. The frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_bit_deframer #(
   parameter int FRAME_BYTES = hdlc_df_pkg::FRAME_BYTES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire hdlc_df_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output hdlc_df_pkg::rsp_type  rsp_data
);

   `include "hdlc_bit_deframer_macros.svh"

   localparam int AW = $clog2(FRAME_BYTES);

   logic                  in_valid_ff;
   hdlc_df_pkg::req_type  in_data_ff;
   logic                  rsp_valid_ff;
   logic [hdlc_df_pkg::EVENT_W-1:0] ev_ff, ev_in;
   logic [hdlc_df_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                  go;
   hdlc_df_pkg::ctl_type  ctl;
   logic [AW-1:0]         wr_pos;
   logic [hdlc_df_pkg::LEN_W-1:0]   frame_len;
   logic                  fcs_ok;
   logic [hdlc_df_pkg::BYTE_W-1:0]  rd_byte;

   // Advance when the result register is empty or being drained
   assign go        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   hdlc_df_ctrl #(.FRAME_BYTES(FRAME_BYTES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .item      (in_data_ff),
      .ctl       (ctl),
      .wr_pos    (wr_pos),
      .frame_len (frame_len)
   );

   hdlc_df_fcs u_fcs (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .fcs_ok (fcs_ok)
   );

   hdlc_df_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
      .clock      (clock),
      .ctl        (ctl),
      .wr_pos     (wr_pos),
      .read_index (in_data_ff.read_index),
      .read_byte  (rd_byte)
   );

   always_comb begin
      ev_in  = hdlc_df_pkg::EV_NONE;
      len_in = '0;
      if (ctl.is_read) begin
         ev_in = hdlc_df_pkg::EV_READ;
      end else if (ctl.closing) begin
         if (fcs_ok) begin
            ev_in  = hdlc_df_pkg::EV_GOOD;
            len_in = frame_len;
         end else begin
            ev_in = hdlc_df_pkg::EV_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ev_ff  <= ev_in;
         len_ff <= len_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.event_res    = ev_ff;
      rsp_data.frame_length = len_ff;
      rsp_data.read_byte    = rd_byte;
   end

   `HDF_ASSERT_NEXT(a_result_follows, go, rsp_valid_ff,
      "processed item left no result")
   `HDF_ASSERT_NOW(a_good_len, rsp_valid_ff && (ev_ff == hdlc_df_pkg::EV_GOOD),
      len_ff > hdlc_df_pkg::LEN_W'(hdlc_df_pkg::MIN_CLOSE_BYTES),
      "good frame reported with too few bytes")

endmodule

`default_nettype wire
